>>> sv/var_pkg.sv
// shared widths, status codes and helpers for the vector alignment rotation block
package var_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 14;
    localparam int OUT_W     = 16;
    localparam int ST_W      = 2;

    // prescaled vectors keep their largest magnitude in [2^NRM, 2^(NRM+1))
    localparam int NRM    = 13;
    localparam int CW     = NRM + 2;
    localparam int POS_W  = $clog2(IN_WIDTH);
    localparam int SH_W   = IN_WIDTH + NRM;

    localparam int PR_W   = 2 * CW;
    localparam int SQ_W   = 2 * NRM + 4;
    localparam int DT_W   = 2 * NRM + 5;
    localparam int WC_W   = 2 * NRM + 4;
    localparam int PQ_W   = 2 * SQ_W;
    localparam int S_W    = SQ_W;
    localparam int T_W    = S_W + 2;
    localparam int M_W    = S_W + T_W - 1;
    localparam int WT_W   = WC_W + T_W;
    localparam int WW_W   = 2 * WC_W;
    localparam int NUM_W  = DT_W + T_W;
    localparam int R_W    = M_W + 1;
    localparam int Q_W    = FRAC_BITS + 2;

    localparam int ISQ_LAT = S_W;
    localparam int DIV_LAT = FRAC_BITS + 4;
    localparam int LAT     = 6 + ISQ_LAT + 3 + DIV_LAT + 1;

    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1 << FRAC_BITS);

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_SAME     = 2'd2,
        ST_OPPOSITE = 2'd3
    } t_status;

    typedef struct packed {
        logic zero;
        logic near;
        logic dneg;
        logic tneg;
    } t_flag;

    function automatic logic [POS_W-1:0] lead_pos(input logic [IN_WIDTH-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < IN_WIDTH; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> sv/var_isqrt.sv
// pipelined integer square root, one result bit per stage
module var_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [var_pkg::PQ_W-1:0]    i_x,
    output logic [var_pkg::S_W-1:0]     o_root
);
    import var_pkg::*;

    localparam int RM_W = S_W + 2;

    logic [RM_W-1:0] r_rem  [S_W-1];
    logic [PQ_W-1:0] r_x    [S_W-1];
    logic [S_W-1:0]  r_root [S_W];

    for (genvar k = 0; k < S_W; k++) begin : g_stage
        logic [RM_W-1:0] w_rin;
        logic [RM_W-1:0] w_rs;
        logic [RM_W-1:0] w_t;
        logic [S_W-1:0]  w_qin;
        logic [PQ_W-1:0] w_xin;
        logic            w_ge;
        logic [RM_W-1:0] n_rem;
        logic [S_W-1:0]  n_root;

        if (k == 0) begin : g_first
            assign w_rin = '0;
            assign w_qin = '0;
            assign w_xin = i_x;
        end else begin : g_next
            assign w_rin = r_rem[k-1];
            assign w_qin = r_root[k-1];
            assign w_xin = r_x[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign w_rs   = {w_rin[RM_W-3:0], w_xin[2*(S_W-1-k) +: 2]};
        assign w_t    = {w_qin, 2'b01};
        assign w_ge   = (w_rs >= w_t);
        assign n_rem  = w_ge ? (w_rs - w_t) : w_rs;
        assign n_root = {w_qin[S_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
            end
        end

        if (k < S_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_x[k]   <= w_xin;
                end
            end
        end
    end

    assign o_root = r_root[S_W-1];

endmodule

>>> sv/var_fxdiv.sv
// pipelined fixed-point divider with rounding and saturation to plus or minus one
module var_fxdiv (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [var_pkg::NUM_W-1:0]  i_num,
    input  logic        [var_pkg::M_W-1:0]    i_den,
    output logic signed [var_pkg::OUT_W-1:0]  o_val
);
    import var_pkg::*;

    localparam int NF = FRAC_BITS + 1;
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1 << FRAC_BITS);

    // magnitude stage
    logic             r_neg_a;
    logic [NUM_W-1:0] r_mag_a;
    logic [M_W-1:0]   r_den_a;

    // integer bit stage
    logic             r_neg_b;
    logic             r_sat_b;
    logic [R_W-1:0]   r_rem_b;
    logic [Q_W-1:0]   r_quo_b;
    logic [M_W-1:0]   r_den_b;

    logic             n_sat;
    logic             n_int;
    logic [R_W-1:0]   n_rem;

    // fraction stages
    logic [R_W-1:0]   r_rem [NF-1];
    logic [M_W-1:0]   r_den [NF-1];
    logic [Q_W-1:0]   r_quo [NF];
    logic             r_sat [NF];
    logic             r_neg [NF];

    logic [Q_W-1:0]          n_rnd;
    logic [Q_W-1:0]          n_mag;
    logic signed [Q_W-1:0]   n_val;
    logic signed [OUT_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_num[NUM_W-1];
            r_mag_a <= i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_den_a <= i_den;
        end
    end

    assign n_sat = (r_mag_a >= NUM_W'({r_den_a, 1'b0}));
    assign n_int = (r_mag_a >= NUM_W'(r_den_a));
    assign n_rem = n_int ? R_W'(r_mag_a - NUM_W'(r_den_a)) : R_W'(r_mag_a);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_b <= r_neg_a;
            r_sat_b <= n_sat;
            r_rem_b <= n_rem;
            r_quo_b <= Q_W'(n_int);
            r_den_b <= r_den_a;
        end
    end

    for (genvar j = 0; j < NF; j++) begin : g_frac
        logic [R_W-1:0] w_rin;
        logic [M_W-1:0] w_den;
        logic [Q_W-1:0] w_qin;
        logic           w_sat;
        logic           w_neg;
        logic [R_W-1:0] w_rs;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_rin = r_rem_b;
            assign w_den = r_den_b;
            assign w_qin = r_quo_b;
            assign w_sat = r_sat_b;
            assign w_neg = r_neg_b;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_den = r_den[j-1];
            assign w_qin = r_quo[j-1];
            assign w_sat = r_sat[j-1];
            assign w_neg = r_neg[j-1];
        end

        assign w_rs = {w_rin[R_W-2:0], 1'b0};
        assign w_ge = (w_rs >= R_W'(w_den));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= {w_qin[Q_W-2:0], w_ge};
                r_sat[j] <= w_sat;
                r_neg[j] <= w_neg;
            end
        end

        if (j < NF - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? (w_rs - R_W'(w_den)) : w_rs;
                    r_den[j] <= w_den;
                end
            end
        end
    end

    // round half away from zero on the magnitude, then clamp to one
    always_comb begin
        n_rnd = Q_W'(({1'b0, r_quo[NF-1]} + (Q_W + 1)'(1)) >> 1);
        n_mag = (r_sat[NF-1] || (n_rnd > ONE_Q)) ? ONE_Q : n_rnd;
        n_val = r_neg[NF-1] ? -$signed(n_mag) : $signed(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= OUT_W'(n_val);
        end
    end

    assign o_val = r_out;

endmodule

>>> sv/vector_alignment_rotation.sv
// top level: rotation matrix that turns one 3-d vector onto another
//
// Takes a source and a target vector as signed integers and returns the 3x3 rotation
// matrix (row-major, Q2.14, rounded to nearest and clamped to +-1.0) that turns the
// source direction onto the target direction. A pair can be accepted every clock while
// the output is not stalled. Most of the pipeline depth comes from the bit-per-stage
// square root (30 stages) and the nine bit-per-stage dividers (18 stages) that follow
// it. A stall on the output holds the whole pipeline.
// Status: 0 ok, 1 a zero-length input, 2 vectors in the same direction, 3 opposite
// direction; every status other than 0 comes with the identity matrix.
module vector_alignment_rotation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [var_pkg::IN_WIDTH-1:0] i_first_x,
    input  logic signed [var_pkg::IN_WIDTH-1:0] i_first_y,
    input  logic signed [var_pkg::IN_WIDTH-1:0] i_first_z,
    input  logic signed [var_pkg::IN_WIDTH-1:0] i_second_x,
    input  logic signed [var_pkg::IN_WIDTH-1:0] i_second_y,
    input  logic signed [var_pkg::IN_WIDTH-1:0] i_second_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [var_pkg::OUT_W-1:0]    o_r00,
    output logic signed [var_pkg::OUT_W-1:0]    o_r01,
    output logic signed [var_pkg::OUT_W-1:0]    o_r02,
    output logic signed [var_pkg::OUT_W-1:0]    o_r10,
    output logic signed [var_pkg::OUT_W-1:0]    o_r11,
    output logic signed [var_pkg::OUT_W-1:0]    o_r12,
    output logic signed [var_pkg::OUT_W-1:0]    o_r20,
    output logic signed [var_pkg::OUT_W-1:0]    o_r21,
    output logic signed [var_pkg::OUT_W-1:0]    o_r22,
    output logic        [var_pkg::ST_W-1:0]     o_status
);
    import var_pkg::*;

    logic                   w_en;
    logic [LAT-1:0]         r_vld;
    logic signed [IN_WIDTH-1:0] w_in [6];

    // stage 1..3: prescale
    logic [IN_WIDTH-1:0]    r1_mag [6];
    logic                   r1_neg [6];
    logic [IN_WIDTH-1:0]    r2_mag [6];
    logic                   r2_neg [6];
    logic [POS_W-1:0]       r2_pos [2];
    logic                   r2_zero;
    logic signed [CW-1:0]   r3_c [6];
    logic                   r3_zero;

    // stage 4..8: products, sums, near-parallel test
    logic signed [PR_W-1:0] r4_sq [6];
    logic signed [PR_W-1:0] r4_cd [3];
    logic signed [PR_W-1:0] r4_x  [6];
    logic                   r4_zero;
    logic [SQ_W-1:0]        r5_p;
    logic [SQ_W-1:0]        r5_q;
    logic signed [DT_W-1:0] r5_d;
    logic signed [WC_W-1:0] r5_w [3];
    logic                   r5_zero;
    logic [PQ_W-1:0]        r6_pq;
    logic signed [WW_W-1:0] r6_ws [3];
    logic signed [DT_W-1:0] r6_d;
    logic signed [WC_W-1:0] r6_w [3];
    logic                   r6_zero;
    logic [PQ_W-1:0]        r7_wsum;
    logic [PQ_W-1:0]        r7_thr;
    t_flag                  r7_flg;
    t_flag                  r8_flg;

    // delay lines beside the square root
    logic signed [DT_W-1:0] r_dl_d [ISQ_LAT];
    logic signed [WC_W-1:0] r_dl_w [ISQ_LAT][3];
    t_flag                  r_flg_a [ISQ_LAT-2];
    logic [S_W-1:0]         w_root;

    // stage 37..39: numerators and denominator
    logic signed [T_W-1:0]  r37_t;
    logic [S_W-1:0]         r37_s;
    logic signed [DT_W-1:0] r37_d;
    logic signed [WC_W-1:0] r37_w [3];
    t_flag                  r37_flg;
    logic [M_W-1:0]         r38_m;
    logic signed [NUM_W-1:0] r38_dt;
    logic signed [WT_W-1:0] r38_wt [3];
    logic signed [WW_W-1:0] r38_ww [6];
    t_flag                  r38_flg;
    logic signed [NUM_W-1:0] r39_num [9];
    logic [M_W-1:0]         r39_m;
    t_flag                  r_flg_b [DIV_LAT+1];

    logic signed [OUT_W-1:0] w_q [9];

    // output stage
    t_flag                   w_flg;
    logic signed [OUT_W-1:0] n_mat [9];
    t_status                 n_status;
    logic signed [OUT_W-1:0] r_mat [9];
    t_status                 r_status;

    // global advance: the pipeline moves unless a waiting result is stalled
    assign o_stall = r_vld[LAT-1] & i_stall;
    assign w_en    = ~o_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign w_in[0] = i_first_x;
    assign w_in[1] = i_first_y;
    assign w_in[2] = i_first_z;
    assign w_in[3] = i_second_x;
    assign w_in[4] = i_second_y;
    assign w_in[5] = i_second_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                r1_neg[k] <= w_in[k][IN_WIDTH-1];
                r1_mag[k] <= w_in[k][IN_WIDTH-1] ? $unsigned(-w_in[k]) : $unsigned(w_in[k]);
            end
        end
    end

    // leading one of the or of the magnitudes is the leading one of the largest
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_pos[0] <= lead_pos(r1_mag[0] | r1_mag[1] | r1_mag[2]);
            r2_pos[1] <= lead_pos(r1_mag[3] | r1_mag[4] | r1_mag[5]);
            r2_zero <= ((r1_mag[0] | r1_mag[1] | r1_mag[2]) == '0)
                    || ((r1_mag[3] | r1_mag[4] | r1_mag[5]) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                logic [SH_W-1:0]   sh;
                logic [NRM:0]      sm;
                sh = (SH_W'(r2_mag[k]) << NRM) >> ((k < 3) ? r2_pos[0] : r2_pos[1]);
                sm = sh[NRM:0];
                r3_c[k] <= r2_neg[k] ? -$signed({1'b0, sm}) : $signed({1'b0, sm});
            end
            r3_zero <= r2_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                r4_sq[k] <= r3_c[k] * r3_c[k];
            end
            for (int k = 0; k < 3; k++) begin
                r4_cd[k] <= r3_c[k] * r3_c[k+3];
            end
            r4_x[0] <= r3_c[1] * r3_c[5];
            r4_x[1] <= r3_c[2] * r3_c[4];
            r4_x[2] <= r3_c[2] * r3_c[3];
            r4_x[3] <= r3_c[0] * r3_c[5];
            r4_x[4] <= r3_c[0] * r3_c[4];
            r4_x[5] <= r3_c[1] * r3_c[3];
            r4_zero <= r3_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_p <= SQ_W'($unsigned(r4_sq[0])) + SQ_W'($unsigned(r4_sq[1]))
                  + SQ_W'($unsigned(r4_sq[2]));
            r5_q <= SQ_W'($unsigned(r4_sq[3])) + SQ_W'($unsigned(r4_sq[4]))
                  + SQ_W'($unsigned(r4_sq[5]));
            r5_d <= DT_W'(r4_cd[0]) + DT_W'(r4_cd[1]) + DT_W'(r4_cd[2]);
            r5_w[0] <= WC_W'(r4_x[0]) - WC_W'(r4_x[1]);
            r5_w[1] <= WC_W'(r4_x[2]) - WC_W'(r4_x[3]);
            r5_w[2] <= WC_W'(r4_x[4]) - WC_W'(r4_x[5]);
            r5_zero <= r4_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_pq <= r5_p * r5_q;
            for (int k = 0; k < 3; k++) begin
                r6_ws[k] <= r5_w[k] * r5_w[k];
            end
            r6_d    <= r5_d;
            r6_w    <= r5_w;
            r6_zero <= r5_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_wsum <= $unsigned(r6_ws[0]) + $unsigned(r6_ws[1]) + $unsigned(r6_ws[2]);
            r7_thr  <= (r6_pq - PQ_W'(1)) >> FRAC_BITS;
            r7_flg  <= '{zero: r6_zero, near: 1'b0, dneg: r6_d[DT_W-1], tneg: 1'b0};
        end
    end

    // squared cross product below one output lsb of the squared length product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_flg <= '{zero: r7_flg.zero, near: (r7_wsum <= r7_thr),
                        dneg: r7_flg.dneg, tneg: r7_flg.tneg};
        end
    end

    var_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r6_pq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_d[0] <= r6_d;
            r_dl_w[0] <= r6_w;
            for (int k = 1; k < ISQ_LAT; k++) begin
                r_dl_d[k] <= r_dl_d[k-1];
                r_dl_w[k] <= r_dl_w[k-1];
            end
            r_flg_a[0] <= r8_flg;
            for (int k = 1; k < ISQ_LAT - 2; k++) begin
                r_flg_a[k] <= r_flg_a[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r37_t   <= $signed({2'b00, w_root}) + T_W'(r_dl_d[ISQ_LAT-1]);
            r37_s   <= w_root;
            r37_d   <= r_dl_d[ISQ_LAT-1];
            r37_w   <= r_dl_w[ISQ_LAT-1];
            r37_flg <= r_flg_a[ISQ_LAT-3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r38_m  <= r37_s * $unsigned(r37_t[T_W-2:0]);
            r38_dt <= r37_d * r37_t;
            for (int k = 0; k < 3; k++) begin
                r38_wt[k] <= r37_w[k] * r37_t;
                r38_ww[k] <= r37_w[k] * r37_w[k];
            end
            r38_ww[3] <= r37_w[0] * r37_w[1];
            r38_ww[4] <= r37_w[0] * r37_w[2];
            r38_ww[5] <= r37_w[1] * r37_w[2];
            r38_flg   <= '{zero: r37_flg.zero, near: r37_flg.near,
                           dneg: r37_flg.dneg, tneg: !(r37_t > 0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r39_num[0] <= r38_dt + NUM_W'(r38_ww[0]);
            r39_num[1] <= NUM_W'(r38_ww[3]) - NUM_W'(r38_wt[2]);
            r39_num[2] <= NUM_W'(r38_wt[1]) + NUM_W'(r38_ww[4]);
            r39_num[3] <= NUM_W'(r38_wt[2]) + NUM_W'(r38_ww[3]);
            r39_num[4] <= r38_dt + NUM_W'(r38_ww[1]);
            r39_num[5] <= NUM_W'(r38_ww[5]) - NUM_W'(r38_wt[0]);
            r39_num[6] <= NUM_W'(r38_ww[4]) - NUM_W'(r38_wt[1]);
            r39_num[7] <= NUM_W'(r38_wt[0]) + NUM_W'(r38_ww[5]);
            r39_num[8] <= r38_dt + NUM_W'(r38_ww[2]);
            r39_m      <= r38_m;
            r_flg_b[0] <= r38_flg;
            for (int k = 1; k < DIV_LAT + 1; k++) begin
                r_flg_b[k] <= r_flg_b[k-1];
            end
        end
    end

    for (genvar e = 0; e < 9; e++) begin : g_div
        var_fxdiv u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r39_num[e]),
            .i_den (r39_m),
            .o_val (w_q[e])
        );
    end

    assign w_flg = r_flg_b[DIV_LAT];

    always_comb begin
        n_status = ST_OK;
        for (int k = 0; k < 9; k++) begin
            n_mat[k] = w_q[k];
        end
        if (w_flg.zero || w_flg.near || w_flg.tneg) begin
            for (int k = 0; k < 9; k++) begin
                n_mat[k] = (k == 0 || k == 4 || k == 8) ? ONE_OUT : '0;
            end
        end
        priority if (w_flg.zero) begin
            n_status = ST_ZERO;
        end else if (w_flg.near) begin
            n_status = w_flg.dneg ? ST_OPPOSITE : ST_SAME;
        end else if (w_flg.tneg) begin
            n_status = ST_OPPOSITE;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mat    <= n_mat;
            r_status <= n_status;
        end
    end

    assign o_r00    = r_mat[0];
    assign o_r01    = r_mat[1];
    assign o_r02    = r_mat[2];
    assign o_r10    = r_mat[3];
    assign o_r11    = r_mat[4];
    assign o_r12    = r_mat[5];
    assign o_r20    = r_mat[6];
    assign o_r21    = r_mat[7];
    assign o_r22    = r_mat[8];
    assign o_status = r_status;

endmodule

>>> test/tb_vector_alignment_rotation.sv
// testbench for the vector alignment rotation block: random and directed vector pairs
`timescale 1ns / 1ps

module tb_vector_alignment_rotation;
    import var_pkg::*;

    typedef struct {
        logic signed [15:0] fx, fy, fz, sx, sy, sz;
    } t_pair;

    typedef struct {
        logic signed [15:0] r [9];
        logic [1:0]         st;
    } t_matrix;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic signed [15:0] i_first_x = 0, i_first_y = 0, i_first_z = 0;
    logic signed [15:0] i_second_x = 0, i_second_y = 0, i_second_z = 0;
    logic o_valid;
    logic i_stall = 0;
    logic signed [15:0] o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    logic [1:0] o_status;

    t_pair   pending_pairs [$];
    t_matrix expected_mats [$];
    int      errors = 0;
    int      send_idle_pct = 37;
    int      recv_idle_pct = 51;
    int      hold_cycles = 0;
    int      hold_reqs = 0;
    int      hold_done = 0;
    bit      send_pause = 0;

    vector_alignment_rotation dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // scale a vector so its largest magnitude lands in [2^13, 2^14)
    function automatic bit normalize(input logic signed [15:0] v [3],
                                     output longint o [3]);
        longint mag [3];
        longint m;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? -longint'(v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 0;
        while (m >= 16384) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < 8192) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) o[i] = v[i] < 0 ? -mag[i] : mag[i];
        return 1;
    endfunction

    function automatic longint sqrt_floor(input longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // round(num * 2^14 / den), ties away from zero, clamped to +-1.0
    function automatic logic signed [15:0] ratio_q14(input longint num,
                                                     input longint unsigned den);
        bit neg;
        longint unsigned n, q, r;
        neg = num < 0;
        n = neg ? -num : num;
        q = n / den;
        r = n % den;
        if (q >= 2) return neg ? -ONE_OUT : ONE_OUT;
        for (int k = 0; k < FRAC_BITS + 1; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        if (q > 16384) q = 16384;
        return neg ? -16'(q) : 16'(q);
    endfunction

    function automatic t_matrix rotation_of(input t_pair p);
        t_matrix res;
        logic signed [15:0] a [3], b [3];
        longint c [3], d [3], w [3], dot, t;
        longint unsigned pp, qq, pq, wsq, s, m;
        a = '{p.fx, p.fy, p.fz};
        b = '{p.sx, p.sy, p.sz};
        res.r = '{ONE_OUT, 0, 0, 0, ONE_OUT, 0, 0, 0, ONE_OUT};
        res.st = ST_OK;
        if (!normalize(a, c) || !normalize(b, d)) begin
            res.st = ST_ZERO;
            return res;
        end
        pp = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
        qq = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
        pq = pp * qq;
        dot = c[0]*d[0] + c[1]*d[1] + c[2]*d[2];
        w[0] = c[1]*d[2] - c[2]*d[1];
        w[1] = c[2]*d[0] - c[0]*d[2];
        w[2] = c[0]*d[1] - c[1]*d[0];
        wsq = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
        if (wsq <= ((pq - 1) >> FRAC_BITS)) begin
            res.st = dot >= 0 ? ST_SAME : ST_OPPOSITE;
            return res;
        end
        s = sqrt_floor(pq);
        t = longint'(s) + dot;
        if (t <= 0) begin
            res.st = ST_OPPOSITE;
            return res;
        end
        m = s * t;
        res.r[0] = ratio_q14(dot*t + w[0]*w[0], m);
        res.r[1] = ratio_q14(-w[2]*t + w[0]*w[1], m);
        res.r[2] = ratio_q14(w[1]*t + w[0]*w[2], m);
        res.r[3] = ratio_q14(w[2]*t + w[0]*w[1], m);
        res.r[4] = ratio_q14(dot*t + w[1]*w[1], m);
        res.r[5] = ratio_q14(-w[0]*t + w[1]*w[2], m);
        res.r[6] = ratio_q14(-w[1]*t + w[0]*w[2], m);
        res.r[7] = ratio_q14(w[0]*t + w[1]*w[2], m);
        res.r[8] = ratio_q14(dot*t + w[2]*w[2], m);
        return res;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 8)) - 16'sd4;
            3: return 16'($urandom_range(0, 512)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pair(input int fx, fy, fz, sx, sy, sz);
        t_pair p;
        p.fx = fx; p.fy = fy; p.fz = fz;
        p.sx = sx; p.sy = sy; p.sz = sz;
        pending_pairs.push_back(p);
    endtask

    task automatic add_random_pair();
        t_pair p;
        int k;
        p.fx = rand_comp(); p.fy = rand_comp(); p.fz = rand_comp();
        k = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            // scaled copy: same direction
            0: begin
                p.sx = p.fx / k; p.sy = p.fy / k; p.sz = p.fz / k;
            end
            // negated copy: opposite direction
            1: begin
                p.sx = -(p.fx / 2) / k; p.sy = -(p.fy / 2) / k;
                p.sz = -(p.fz / 2) / k;
            end
            // halved copy with a small nudge on x and y and a negated z
            2: begin
                p.sx = p.fx / 2 + int'($urandom_range(0, 6)) - 3;
                p.sy = p.fy / 2 + int'($urandom_range(0, 6)) - 3;
                p.sz = -(p.fz / 2);
            end
            3: begin
                p.sx = 0; p.sy = 0; p.sz = 0;
            end
            default: begin
                p.sx = rand_comp(); p.sy = rand_comp(); p.sz = rand_comp();
            end
        endcase
        pending_pairs.push_back(p);
    endtask

    // driver: valid never looks at stall, payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_pairs.size() > 0 && !send_pause &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    t_pair p;
                    p = pending_pairs.pop_front();
                    i_first_x <= p.fx; i_first_y <= p.fy; i_first_z <= p.fz;
                    i_second_x <= p.sx; i_second_y <= p.sy; i_second_z <= p.sz;
                    i_valid <= 1;
                    expected_mats.push_back(rotation_of(p));
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall, with a long hold-off whenever hold_reqs is raised
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1;
        end else if (hold_done < hold_reqs) begin
            hold_done <= hold_done + 1;
            hold_cycles <= 150;
            i_stall <= 1;
        end else begin
            i_stall <= $urandom_range(0, 99) < recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_mats.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                t_matrix e;
                logic signed [15:0] got [9];
                e = expected_mats.pop_front();
                got = '{o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22};
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== e.r[i]) begin
                        $error("r%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                               e.r[i], got[i]);
                        errors++;
                    end
                end
                if (o_status !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, o_status);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_pairs.size() > 0) @(posedge i_clk);
        @(posedge i_clk);
        while (expected_mats.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        add_pair(0, 0, 0, 1, 2, 3);
        add_pair(5, 6, 7, 0, 0, 0);
        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(1, 0, 0, 0, 1, 0);
        add_pair(1, 2, 3, 2, 4, 6);
        add_pair(1, 2, 3, -3, -6, -9);
        add_pair(-32768, -32768, -32768, 32767, 32767, 32767);
        add_pair(-32768, 0, 0, 32767, 0, 0);
        add_pair(32767, -32768, 32767, -32768, 32767, -32768);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-1, -1, -1, 1, -1, 1);
        add_pair(10000, 1, 0, -10000, 0, 0);
        add_pair(10000, 0, 0, -10000, 3, 0);
        add_pair(0, 0, 1, 0, 1, 0);
        add_pair(16384, 8192, -1, 1, 1, 1);
        add_pair(-32768, 32767, 1, 1, -1, -32768);
        drain();

        for (int i = 0; i < 200; i++) add_random_pair();
        drain();

        // sender pauses until every expected result is in
        send_pause = 1;
        while (expected_mats.size() > 0) @(posedge i_clk);
        send_pause = 0;

        send_idle_pct = 51;
        recv_idle_pct = 37;
        for (int i = 0; i < 200; i++) add_random_pair();
        @(posedge i_clk);
        hold_reqs <= hold_reqs + 1;
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 250; i++) add_random_pair();
        drain();

        repeat (LAT + 20) @(posedge i_clk);
        if (errors == 0 && expected_mats.size() == 0)
            $display("** vector_alignment_rotation: PASSED **");
        else
            $display("** vector_alignment_rotation: FAILED **");
        $finish;
    end

    initial begin
        #3000000;
        $display("** vector_alignment_rotation: FAILED **");
        $finish;
    end

endmodule
